@@ rtl/ssp_pkg.sv @@
// Shared types and codes for the segment stop and presteer sequencer.
`timescale 1ns / 1ps

package ssp_pkg;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    INT_NONE      = 3'd0,
    INT_TRACK     = 3'd1,
    INT_STOP      = 3'd2,
    INT_PRESTEER  = 3'd3,
    INT_FINHOLD   = 3'd4,
    INT_EMERGENCY = 3'd5
  } intent_t;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_ACTIVE = 2'd1,
    SRC_LOCAL  = 2'd2
  } src_t;

  localparam logic [2:0] CFG_POS_TOL    = 3'd0;
  localparam logic [2:0] CFG_HEAD_TOL   = 3'd1;
  localparam logic [2:0] CFG_SPEED_TOL  = 3'd2;
  localparam logic [2:0] CFG_ZONE       = 3'd3;
  localparam logic [2:0] CFG_STOP_HOLD  = 3'd4;
  localparam logic [2:0] CFG_PRESTEER   = 3'd5;
  localparam logic [2:0] CFG_FIN_HOLD   = 3'd6;
  localparam logic [2:0] CFG_GLOBAL     = 3'd7;

  localparam int PosW   = 24;
  localparam int HeadW  = 16;
  localparam int SpeedW = 17;
  localparam int SqW    = 2 * (PosW + 1) - 1;

  typedef struct packed {
    logic [SqW-1:0]    dx_sq;
    logic [SqW-1:0]    dy_sq;
    logic [HeadW-1:0]  head_err;
    logic [SpeedW-1:0] speed_abs;
  } geo_t;

endpackage

@@ rtl/ssp_geom.sv @@
// Pose geometry: squared endpoint offsets, wrapped heading error, absolute speed.
`timescale 1ns / 1ps

module ssp_geom (
  input  logic signed [ssp_pkg::PosW-1:0]   ego_x,
  input  logic signed [ssp_pkg::PosW-1:0]   ego_y,
  input  logic        [ssp_pkg::HeadW-1:0]  ego_heading,
  input  logic signed [ssp_pkg::SpeedW-1:0] ego_speed,
  input  logic signed [ssp_pkg::PosW-1:0]   end_x,
  input  logic signed [ssp_pkg::PosW-1:0]   end_y,
  input  logic        [ssp_pkg::HeadW-1:0]  end_heading,
  output ssp_pkg::geo_t                     geo
);
  import ssp_pkg::*;

  logic signed [PosW:0]   dx;
  logic signed [PosW:0]   dy;
  logic        [PosW:0]   ax;
  logic        [PosW:0]   ay;
  logic        [HeadW-1:0] dh;

  assign dx = {ego_x[PosW-1], ego_x} - {end_x[PosW-1], end_x};
  assign dy = {ego_y[PosW-1], ego_y} - {end_y[PosW-1], end_y};
  assign ax = dx[PosW] ? (PosW+1)'(0) - dx : dx;
  assign ay = dy[PosW] ? (PosW+1)'(0) - dy : dy;
  assign dh = ego_heading - end_heading;

  assign geo.dx_sq     = SqW'({{(PosW-1){1'b0}}, ax} * {{(PosW-1){1'b0}}, ax});
  assign geo.dy_sq     = SqW'({{(PosW-1){1'b0}}, ay} * {{(PosW-1){1'b0}}, ay});
  assign geo.head_err  = dh[HeadW-1] ? HeadW'(~dh + 1'b1) : dh;
  assign geo.speed_abs = ego_speed[SpeedW-1] ? SpeedW'(~ego_speed + 1'b1) : ego_speed;

endmodule

@@ rtl/segment_stop_presteer_fsm.sv @@
// Top level of the segment stop and presteer sequencer.
// Usage:
//   One input item per control tick on the in_ channel; in_tuser carries the
//   command (update tick, timeout stop, load path), in_tdata the pose, speed,
//   time, active endpoint and segment total. Each item yields exactly one
//   result item on the out_ channel: state, intent, source, segment
//   index and flags. When advanced is set the next endpoint must be supplied.
//   An accepted item reaches out_tvalid through three registers: input
//   register, squaring stage (one 25x25 multiplier per axis), then decision
//   and state update into the result register. One item is accepted per
//   cycle while in_tready is high. When out_tready is low the result register
//   holds; the two earlier stages keep filling, and in_tready falls only once
//   all three stages are full. Synchronous reset restores the register
//   defaults, clears the path (idle, no segments) and empties the pipeline;
//   no clearing pass is needed. Configuration writes on cfg_ take effect at
//   the next clock edge; the user must make them while the block is idle, which
//   the block does not enforce. Position tolerance and zone are stored squared.
`timescale 1ns / 1ps

module segment_stop_presteer_fsm #(
  parameter int MAX_SEGMENTS = 255
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ego_x[23:0], ego_y[47:24], ego_heading[63:48], ego_speed[80:64],
  // now_ms[112:81], end_x[136:113], end_y[160:137], end_heading[176:161],
  // segment_total[184:177], zero[191:185]
  input  logic [191:0] in_tdata,
  // command[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // publish[0], finished[1], speed_cap[2], planner_state[5:3], intent[8:6],
  // source[10:9], segment_index[18:11], advanced[19], zero[23:20]
  output logic [23:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);
  import ssp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_TRACK    = 3'd1,
    ST_STOP     = 3'd2,
    ST_PRESTEER = 3'd3,
    ST_FINHOLD  = 3'd4
  } state_t;

  localparam logic [7:0] MaxSeg = 8'(MAX_SEGMENTS);

  // configuration
  logic [31:0] pos_tol_sq_r;
  logic [15:0] head_tol_r;
  logic [15:0] speed_tol_r;
  logic [31:0] zone_sq_r;
  logic [15:0] stop_hold_r;
  logic [15:0] presteer_r;
  logic [15:0] fin_hold_r;
  logic        global_r;
  logic [31:0] cfg_sq;

  // pipeline
  logic         s1_valid_r, s2_valid_r, out_valid_r;
  logic         s1_free, s2_free, out_free;
  logic [191:0] s1_data_r;
  cmd_t         s1_cmd_r, s2_cmd_r;
  logic [31:0]  s2_now_r;
  logic [7:0]   s2_total_r;
  geo_t         geo, s2_geo_r;
  logic [23:0]  out_data_r;

  // sequencer state
  state_t      state_r, state_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  cnt_r, cnt_nxt;

  logic [SqW:0] dist_sq;
  logic         reached, precise, zone_ok;
  logic         has_path, path_fin, is_final, is_idle, do_stop;
  logic [7:0]   load_cnt;
  logic [31:0]  dl_stop, dl_pre, dl_fin, stop_dl;
  src_t         src;
  intent_t      intent;
  logic         fin_o, cap_o, adv_o, pub_o;

  assign cfg_sq = {16'b0, cfg_wdata} * {16'b0, cfg_wdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_tol_sq_r <= 32'd40000;
      head_tol_r   <= 16'd1000;
      speed_tol_r  <= 16'd50;
      zone_sq_r    <= 32'd9000000;
      stop_hold_r  <= 16'd500;
      presteer_r   <= 16'd1000;
      fin_hold_r   <= 16'd1000;
      global_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POS_TOL:   pos_tol_sq_r <= cfg_sq;
        CFG_HEAD_TOL:  head_tol_r   <= cfg_wdata;
        CFG_SPEED_TOL: speed_tol_r  <= cfg_wdata;
        CFG_ZONE:      zone_sq_r    <= cfg_sq;
        CFG_STOP_HOLD: stop_hold_r  <= cfg_wdata;
        CFG_PRESTEER:  presteer_r   <= cfg_wdata;
        CFG_FIN_HOLD:  fin_hold_r   <= cfg_wdata;
        CFG_GLOBAL:    global_r     <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_tready = s1_free;

  ssp_geom u_geom (
    .ego_x       (s1_data_r[23:0]),
    .ego_y       (s1_data_r[47:24]),
    .ego_heading (s1_data_r[63:48]),
    .ego_speed   (s1_data_r[80:64]),
    .end_x       (s1_data_r[136:113]),
    .end_y       (s1_data_r[160:137]),
    .end_heading (s1_data_r[176:161]),
    .geo         (geo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= in_tvalid;
      if (s2_free) s2_valid_r <= s1_valid_r;
    end
    if (s1_free && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_cmd_r  <= cmd_t'(in_tuser);
    end
    if (s2_free && s1_valid_r) begin
      s2_geo_r   <= geo;
      s2_cmd_r   <= s1_cmd_r;
      s2_now_r   <= s1_data_r[112:81];
      s2_total_r <= s1_data_r[184:177];
    end
  end

  assign dist_sq  = {1'b0, s2_geo_r.dx_sq} + {1'b0, s2_geo_r.dy_sq};
  assign reached  = (dist_sq <= {{(SqW+1-32){1'b0}}, pos_tol_sq_r}) &&
                    (s2_geo_r.head_err <= head_tol_r);
  assign precise  = reached && (s2_geo_r.speed_abs <= {1'b0, speed_tol_r});
  assign zone_ok  = dist_sq <= {{(SqW+1-32){1'b0}}, zone_sq_r};
  assign has_path = cnt_r != 8'd0;
  assign path_fin = has_path && (idx_r >= cnt_r);
  assign is_final = has_path && (({1'b0, idx_r} + 9'd1) >= {1'b0, cnt_r});
  assign is_idle  = !(state_r == ST_TRACK || state_r == ST_STOP ||
                      state_r == ST_PRESTEER || state_r == ST_FINHOLD);
  assign do_stop  = (state_r == ST_TRACK && reached) || state_r == ST_STOP;
  assign load_cnt = (s2_total_r > MaxSeg) ? MaxSeg : s2_total_r;
  assign dl_stop  = s2_now_r + {16'b0, stop_hold_r};
  assign dl_pre   = s2_now_r + {16'b0, presteer_r};
  assign dl_fin   = s2_now_r + {16'b0, fin_hold_r};
  assign stop_dl  = (state_r == ST_TRACK) ? dl_stop : deadline_r;

  always_comb begin
    state_nxt    = state_r;
    deadline_nxt = deadline_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    src          = SRC_NONE;
    intent       = INT_NONE;
    fin_o        = 1'b0;
    cap_o        = 1'b0;
    adv_o        = 1'b0;
    unique case (s2_cmd_r)
      CMD_LOAD: begin
        cnt_nxt      = load_cnt;
        idx_nxt      = 8'd0;
        deadline_nxt = 32'd0;
        state_nxt    = (load_cnt != 8'd0) ? ST_TRACK : ST_IDLE;
        adv_o        = load_cnt != 8'd0;
      end
      CMD_TIMEOUT: begin
        intent = INT_EMERGENCY;
        if (!has_path || path_fin) fin_o = path_fin;
        else src = SRC_ACTIVE;
      end
      CMD_UNUSED: begin
        fin_o = path_fin;
      end
      CMD_TICK: begin
        priority if (!has_path || path_fin || is_idle) begin
          state_nxt = ST_IDLE;
          fin_o     = path_fin;
        end else if (do_stop) begin
          src = SRC_ACTIVE;
          if (s2_now_r >= stop_dl && precise) begin
            if (is_final) begin
              state_nxt    = ST_FINHOLD;
              deadline_nxt = dl_fin;
              intent       = INT_FINHOLD;
              fin_o        = 1'b1;
            end else begin
              idx_nxt      = idx_r + 8'd1;
              state_nxt    = ST_PRESTEER;
              deadline_nxt = dl_pre;
              intent       = INT_PRESTEER;
              adv_o        = 1'b1;
            end
          end else begin
            state_nxt    = ST_STOP;
            deadline_nxt = stop_dl;
            intent       = INT_STOP;
          end
        end else if (state_r == ST_PRESTEER && s2_now_r < deadline_r) begin
          src    = SRC_ACTIVE;
          intent = INT_PRESTEER;
        end else if (state_r == ST_FINHOLD) begin
          fin_o = 1'b1;
          if (s2_now_r >= deadline_r) begin
            idx_nxt   = idx_r + 8'd1;
            state_nxt = ST_IDLE;
            adv_o     = 1'b1;
          end else begin
            src    = SRC_ACTIVE;
            intent = INT_FINHOLD;
          end
        end else begin
          state_nxt = ST_TRACK;
          src       = global_r ? SRC_ACTIVE : SRC_LOCAL;
          intent    = INT_TRACK;
          cap_o     = is_final && zone_ok && !reached;
        end
      end
    endcase
    pub_o = (src != SRC_NONE) && (idx_nxt < cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= ST_IDLE;
      deadline_r  <= 32'd0;
      idx_r       <= 8'd0;
      cnt_r       <= 8'd0;
    end else if (out_free) begin
      out_valid_r <= s2_valid_r;
      if (s2_valid_r) begin
        state_r    <= state_nxt;
        deadline_r <= deadline_nxt;
        idx_r      <= idx_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
    if (out_free && s2_valid_r) begin
      out_data_r <= {4'b0, adv_o, idx_nxt, src, intent, state_nxt,
                     cap_o, fin_o, pub_o};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_publish_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> out_data_r[10:9] != SRC_NONE)
    else $error("publish without a path source");

  a_cap_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[2] |-> out_data_r[8:6] == INT_TRACK)
    else $error("speed cap outside tracking");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MaxSeg)
    else $error("segment count above maximum");

  a_idle_no_pub: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[5:3] == ST_IDLE && out_data_r[8:6] != INT_EMERGENCY
    |-> !out_data_r[0])
    else $error("publish while idle");

endmodule
